/* hw/rtl/skt_pkg.sv */
// Shared types, field widths and codes for the sorted key table.
// No dependencies; imported by every module of the block.
package skt_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int STAT_W = 3;
    localparam int POS_W  = 4;

    localparam int S_TDATA_W = ((2 * KEY_W + PAY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((POS_W + KEY_W + PAY_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
    localparam logic [OP_W-1:0] OP_RANGE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY_TABLE = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY_RANGE = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] key_upper;
        logic [PAY_W-1:0]        payload;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [POS_W-1:0]        position;
        logic signed [KEY_W-1:0] entry_key;
        logic [PAY_W-1:0]        entry_payload;
        logic                    last;
    } res_t;

endpackage

/* hw/rtl/skt_mem.sv */
// Entry storage: key and payload arrays, one write port, one registered read port.
// Depends on skt_pkg for field widths.
module skt_mem import skt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic signed [KEY_W-1:0]    wr_key,
    input  logic [PAY_W-1:0]           wr_pay,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic signed [KEY_W-1:0]    rd_key,
    output logic [PAY_W-1:0]           rd_pay
);

    logic signed [KEY_W-1:0] key_mem [DEPTH];
    logic [PAY_W-1:0]        pay_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key <= key_mem[rd_addr];
        rd_pay <= pay_mem[rd_addr];
    end

endmodule

/* hw/rtl/skt_ctrl.sv */
// Sequencer: binary search, entry shifting, range scan and result emission,
// all through one signed key comparator and the single read port of skt_mem.
// Depends on skt_pkg.
module skt_ctrl import skt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  cmd_t                       cmd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output res_t                       res,
    output logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic signed [KEY_W-1:0]    rd_key,
    input  logic [PAY_W-1:0]           rd_pay,
    output logic                       wr_en,
    output logic [$clog2(DEPTH)-1:0]   wr_addr,
    output logic signed [KEY_W-1:0]    wr_key,
    output logic [PAY_W-1:0]           wr_pay
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_CHK_RD   = 4'd3;
    localparam logic [3:0] S_CHK      = 4'd4;
    localparam logic [3:0] S_SHU_RD   = 4'd5;
    localparam logic [3:0] S_SHU_WR   = 4'd6;
    localparam logic [3:0] S_INS_WR   = 4'd7;
    localparam logic [3:0] S_SHD_RD   = 4'd8;
    localparam logic [3:0] S_SHD_WR   = 4'd9;
    localparam logic [3:0] S_SCAN_RD  = 4'd10;
    localparam logic [3:0] S_SCAN_CMP = 4'd11;
    localparam logic [3:0] S_EM_RD    = 4'd12;
    localparam logic [3:0] S_EM_OUT   = 4'd13;
    localparam logic [3:0] S_RES      = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] end_reg, end_next;

    cmd_t                    cmd_reg, cmd_next;
    logic [STAT_W-1:0]       rstat_reg, rstat_next;
    logic [POS_W-1:0]        rpos_reg, rpos_next;
    logic signed [KEY_W-1:0] rkey_reg, rkey_next;
    logic [PAY_W-1:0]        rpay_reg, rpay_next;

    logic [CNT_W:0]          mid_sum;
    logic [CNT_W-1:0]        mid;
    logic [CNT_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        idx_dec;
    logic signed [KEY_W-1:0] cmp_b;
    logic                    key_lt;
    logic                    key_eq;
    logic                    scan_done;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign idx_inc = idx_reg + 1'b1;
    assign idx_dec = idx_reg - 1'b1;

    // shared comparator
    assign cmp_b  = (state_reg == S_SCAN_CMP) ? cmd_reg.key_upper : cmd_reg.key;
    assign key_lt = rd_key < cmp_b;
    assign key_eq = rd_key == cmp_b;

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb begin
        unique case (state_reg)
            S_SRCH_RD: rd_addr = mid[IDX_W-1:0];
            S_CHK_RD:  rd_addr = lo_reg[IDX_W-1:0];
            S_SHU_RD:  rd_addr = idx_dec[IDX_W-1:0];
            S_SHD_RD:  rd_addr = idx_inc[IDX_W-1:0];
            default:   rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        cmd_next   = cmd_reg;
        rstat_next = rstat_reg;
        rpos_next  = rpos_reg;
        rkey_next  = rkey_reg;
        rpay_next  = rpay_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[IDX_W-1:0];
        wr_key     = rd_key;
        wr_pay     = rd_pay;
        res_valid  = 1'b0;
        scan_done  = 1'b0;
        res        = '{status: rstat_reg, position: rpos_reg, entry_key: rkey_reg,
                       entry_payload: rpay_reg, last: 1'b1};

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next  = cmd;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    rpos_next = '0;
                    rkey_next = '0;
                    rpay_next = '0;
                    if (cmd.op == OP_INSERT) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            rstat_next = ST_FULL;
                            state_next = S_RES;
                        end else begin
                            state_next = S_SRCH_RD;
                        end
                    end else if (count_reg == '0) begin
                        rstat_next = ST_EMPTY_TABLE;
                        state_next = S_RES;
                    end else if (cmd.op == OP_LIST) begin
                        idx_next   = '0;
                        end_next   = count_reg;
                        state_next = S_EM_RD;
                    end else begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    state_next = S_SRCH_CMP;
                end else if (cmd_reg.op == OP_RANGE) begin
                    idx_next   = lo_reg;
                    state_next = S_SCAN_RD;
                end else if (lo_reg < count_reg) begin
                    state_next = S_CHK_RD;
                end else if (cmd_reg.op == OP_INSERT) begin
                    idx_next   = count_reg;
                    state_next = S_SHU_RD;
                end else begin
                    rstat_next = ST_NOT_FOUND;
                    state_next = S_RES;
                end
            end
            S_SRCH_CMP: begin
                if (!key_lt) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid + 1'b1;
                end
                state_next = S_SRCH_RD;
            end
            S_CHK_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (cmd_reg.op == OP_INSERT) begin
                    if (key_eq) begin
                        rstat_next = ST_DUPLICATE;
                        rpos_next  = POS_W'(lo_reg);
                        rkey_next  = rd_key;
                        rpay_next  = rd_pay;
                        state_next = S_RES;
                    end else begin
                        idx_next   = count_reg;
                        state_next = S_SHU_RD;
                    end
                end else if (key_eq) begin
                    rstat_next = ST_OK;
                    rpos_next  = POS_W'(lo_reg);
                    rkey_next  = rd_key;
                    rpay_next  = rd_pay;
                    idx_next   = lo_reg;
                    state_next = S_SHD_RD;
                end else begin
                    rstat_next = ST_NOT_FOUND;
                    state_next = S_RES;
                end
            end
            S_SHU_RD: begin
                if (idx_reg > lo_reg) begin
                    state_next = S_SHU_WR;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_SHU_WR: begin
                wr_en      = 1'b1;
                idx_next   = idx_dec;
                state_next = S_SHU_RD;
            end
            S_INS_WR: begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[IDX_W-1:0];
                wr_key     = cmd_reg.key;
                wr_pay     = cmd_reg.payload;
                count_next = count_reg + 1'b1;
                rstat_next = ST_OK;
                rpos_next  = POS_W'(lo_reg);
                rkey_next  = cmd_reg.key;
                rpay_next  = cmd_reg.payload;
                state_next = S_RES;
            end
            S_SHD_RD: begin
                if (idx_inc < count_reg) begin
                    state_next = S_SHD_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RES;
                end
            end
            S_SHD_WR: begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_SHD_RD;
            end
            S_SCAN_RD: begin
                if (idx_reg < count_reg) begin
                    state_next = S_SCAN_CMP;
                end else begin
                    scan_done = 1'b1;
                end
            end
            S_SCAN_CMP: begin
                if (key_lt || key_eq) begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end else begin
                    scan_done = 1'b1;
                end
            end
            S_EM_RD: begin
                state_next = S_EM_OUT;
            end
            S_EM_OUT: begin
                res_valid = 1'b1;
                res       = '{status: ST_OK, position: POS_W'(idx_reg), entry_key: rd_key,
                              entry_payload: rd_pay, last: (idx_inc == end_reg)};
                if (res_ready) begin
                    if (idx_inc == end_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = S_EM_RD;
                    end
                end
            end
            S_RES: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // range bound found: scan pointer marks the end
        if (scan_done) begin
            end_next = idx_reg;
            if (idx_reg == lo_reg) begin
                rstat_next = ST_EMPTY_RANGE;
                state_next = S_RES;
            end else begin
                idx_next   = lo_reg;
                state_next = S_EM_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            idx_reg   <= '0;
            end_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        rstat_reg <= rstat_next;
        rpos_reg  <= rpos_next;
        rkey_reg  <= rkey_next;
        rpay_reg  <= rpay_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == S_INS_WR || $past(state_reg) == S_SHD_RD))
        else $error("entry count changed outside insert or delete");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd_ready && res_valid))
        else $error("result offered while accepting a transaction");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res.last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after final result");

    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EM_OUT) |-> (idx_reg < end_reg))
        else $error("emit pointer past end");

endmodule

/* hw/rtl/sorted_key_table_core.sv */
// Top level of the sorted key table: stream ports, field unpacking and output register.
// Instantiates skt_ctrl and skt_mem; depends on skt_pkg.
//
//  channel  direction  signals                          content
//  s_       in         s_tvalid s_tready s_tdata s_tuser  one operation per transaction
//  m_       out        m_tvalid m_tready m_tdata m_tuser  results, m_tlast on final one
//           m_tlast
//
// Insert/delete: binary search, slot check, then each moved entry is shifted.
// List emits each entry in turn; range: search, scan up to key_upper, then emission.
// Each step uses the single read port of the entry memory (one read, then its use).
// s_tready is high only while the sequencer is idle; a result waiting in the output
// register does not hold it low. Reset empties the table at once.
module sorted_key_table_core import skt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // key, key_upper, payload
    input  logic [OP_W-1:0]       s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // position, entry_key, entry_payload, zero pad
    output logic [STAT_W-1:0]     m_tuser,   // status
    output logic                  m_tlast
);

    localparam int IDX_W = $clog2(DEPTH);

    cmd_t                    cmd;
    res_t                    res;
    logic                    res_valid;
    logic                    res_ready;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [KEY_W-1:0] rd_key;
    logic [PAY_W-1:0]        rd_pay;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_key;
    logic [PAY_W-1:0]        wr_pay;

    logic m_tvalid_reg, m_tvalid_next;
    res_t out_reg, out_next;

    assign cmd = '{op:        s_tuser,
                   key:       s_tdata[KEY_W-1:0],
                   key_upper: s_tdata[2*KEY_W-1:KEY_W],
                   payload:   s_tdata[2*KEY_W+PAY_W-1:2*KEY_W]};

    skt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_pay    (rd_pay),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_pay    (wr_pay)
    );

    skt_mem #(.DEPTH(DEPTH)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_pay  (wr_pay),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_pay  (rd_pay)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            out_next      = res;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {{(M_TDATA_W - POS_W - KEY_W - PAY_W){1'b0}},
                       out_reg.entry_payload, out_reg.entry_key, out_reg.position};

endmodule

/* dv/sorted_key_table_core_test.sv */
// Self-checking stream testbench for sorted_key_table_core: directed and random table operations.
// A built-in table predictor checks every result transaction; depends on skt_pkg and the RTL.
module sorted_key_table_core_test import skt_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_N    = 24;
    localparam int N_RANDOM  = 480;
    localparam int DRAIN_CYC = 200;
    localparam int CYC_LIMIT = 2_000_000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 m_tlast;

    sorted_key_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    cmd_t pending_ops[$];
    res_t results_due[$];

    logic signed [KEY_W-1:0] tbl_key [DEPTH_DEF];
    logic [PAY_W-1:0]        tbl_pay [DEPTH_DEF];
    int                      tbl_count = 0;

    logic signed [KEY_W-1:0] key_pool [POOL_N];
    int                      errors = 0;
    int                      cycles = 0;

    cmd_t drv_item;
    res_t want;
    int   s_gap = 0, s_stretch = 0, m_gap = 0, m_stretch = 0;
    bit   s_quiet = 1'b0, m_quiet = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int draw_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int find_slot(logic signed [KEY_W-1:0] k);
        int lo, hi, mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (k <= tbl_key[mid]) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic void add_due(logic [STAT_W-1:0] st, int pos,
                                    logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p, bit lst);
        res_t r;
        r.status        = st;
        r.position      = POS_W'(pos);
        r.entry_key     = k;
        r.entry_payload = p;
        r.last          = lst;
        results_due.push_back(r);
    endfunction

    task automatic apply_table_op(cmd_t c);
        int s, i, stop;
        logic signed [KEY_W-1:0] k, ku;
        k  = c.key;
        ku = c.key_upper;
        if (c.op == OP_INSERT) begin
            if (tbl_count >= DEPTH_DEF) begin
                add_due(ST_FULL, 0, '0, '0, 1'b1);
            end else begin
                s = find_slot(k);
                if (s < tbl_count && tbl_key[s] == k) begin
                    add_due(ST_DUPLICATE, s, tbl_key[s], tbl_pay[s], 1'b1);
                end else begin
                    for (i = tbl_count; i > s; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_pay[i] = tbl_pay[i-1];
                    end
                    tbl_key[s] = k;
                    tbl_pay[s] = c.payload;
                    tbl_count++;
                    add_due(ST_OK, s, k, c.payload, 1'b1);
                end
            end
        end else if (tbl_count == 0) begin
            add_due(ST_EMPTY_TABLE, 0, '0, '0, 1'b1);
        end else if (c.op == OP_DELETE) begin
            s = find_slot(k);
            if (s >= tbl_count || tbl_key[s] != k) begin
                add_due(ST_NOT_FOUND, 0, '0, '0, 1'b1);
            end else begin
                add_due(ST_OK, s, tbl_key[s], tbl_pay[s], 1'b1);
                for (i = s; i + 1 < tbl_count; i++) begin
                    tbl_key[i] = tbl_key[i+1];
                    tbl_pay[i] = tbl_pay[i+1];
                end
                tbl_count--;
            end
        end else if (c.op == OP_LIST) begin
            for (i = 0; i < tbl_count; i++)
                add_due(ST_OK, i, tbl_key[i], tbl_pay[i], i + 1 == tbl_count);
        end else begin
            s = find_slot(k);
            stop = s;
            while (stop < tbl_count && tbl_key[stop] <= ku) stop++;
            if (stop <= s) begin
                add_due(ST_EMPTY_RANGE, 0, '0, '0, 1'b1);
            end else begin
                for (i = s; i < stop; i++)
                    add_due(ST_OK, i, tbl_key[i], tbl_pay[i], i + 1 == stop);
            end
        end
    endtask

    function automatic void add_op(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k,
                                   logic signed [KEY_W-1:0] ku, logic [PAY_W-1:0] p);
        cmd_t c;
        c.op        = op;
        c.key       = k;
        c.key_upper = ku;
        c.payload   = p;
        pending_ops.push_back(c);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 85) return key_pool[$urandom_range(POOL_N - 1)];
        return $urandom;
    endfunction

    task automatic build_stimulus();
        int i, r, phase_left;
        bit filling;
        logic signed [KEY_W-1:0] lo, hi, t;
        logic [OP_W-1:0] op;

        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        for (i = 4; i < POOL_N; i++)
            key_pool[i] = (i % 2) ? $urandom : $signed($urandom_range(200)) - 100;

        // empty table on every operation but insert
        add_op(OP_LIST,   0, 0, 0);
        add_op(OP_DELETE, 5, 0, 0);
        add_op(OP_RANGE,  -10, 10, 0);
        add_op(OP_INSERT, 32'sh8000_0000, 0, 32'hffff_ffff);
        add_op(OP_INSERT, 32'sh7fff_ffff, 0, 32'h0000_0000);
        add_op(OP_INSERT, 0, 0, $urandom);
        add_op(OP_INSERT, 32'sh7fff_ffff, 0, $urandom);
        add_op(OP_DELETE, 12345, 0, 0);
        add_op(OP_RANGE,  10, -10, 0);
        add_op(OP_RANGE,  1, 100, 0);
        add_op(OP_RANGE,  32'sh8000_0000, 32'sh7fff_ffff, 0);
        add_op(OP_DELETE, 32'sh8000_0000, 0, 0);
        for (i = 0; i < 14; i++)
            add_op(OP_INSERT, ((i * 5) % 14) + 1, 0, $urandom);
        add_op(OP_INSERT, -5, 0, $urandom);
        add_op(OP_LIST,   0, 0, 0);
        add_op(OP_RANGE,  3, 8, 0);

        filling = 1'b0;
        phase_left = 0;
        for (i = 0; i < N_RANDOM; i++) begin
            if (phase_left == 0) begin
                filling = ~filling;
                phase_left = $urandom_range(15, 45);
            end
            phase_left--;
            r = $urandom_range(99);
            if (r < 65)      op = filling ? OP_INSERT : OP_DELETE;
            else if (r < 75) op = filling ? OP_DELETE : OP_INSERT;
            else if (r < 85) op = OP_LIST;
            else             op = OP_RANGE;
            lo = pick_key();
            hi = pick_key();
            r = $urandom_range(99);
            if (r < 10) hi = lo;
            else if (r < 85 && lo > hi) begin
                t = lo;
                lo = hi;
                hi = t;
            end
            add_op(op, lo, (op == OP_RANGE) ? hi : $signed($urandom), $urandom);
        end
    endtask

    initial begin
        build_stimulus();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_ops.size() == 0 && !s_tvalid && results_due.size() == 0);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_table_op(drv_item);
            if (!s_tvalid || s_tready) begin
                if (s_stretch == 0) begin
                    s_stretch = $urandom_range(8, 40);
                    s_quiet   = $urandom_range(99) < 30;
                end
                s_stretch--;
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    drv_item = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {drv_item.payload, drv_item.key_upper, drv_item.key};
                    s_tuser  <= drv_item.op;
                    s_gap    = draw_gap(s_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result transaction: status %0d", m_tuser);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[POS_W-1:0] !== want.position) begin
                        $error("position: expected %0d actual %0d",
                               want.position, m_tdata[POS_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[POS_W +: KEY_W] !== want.entry_key) begin
                        $error("entry_key: expected %0d actual %0d",
                               want.entry_key, $signed(m_tdata[POS_W +: KEY_W]));
                        errors++;
                    end
                    if (m_tdata[POS_W + KEY_W +: PAY_W] !== want.entry_payload) begin
                        $error("entry_payload: expected %h actual %h",
                               want.entry_payload, m_tdata[POS_W + KEY_W +: PAY_W]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d actual %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (m_stretch == 0) begin
                m_stretch = $urandom_range(8, 40);
                m_quiet   = $urandom_range(99) < 30;
            end
            m_stretch--;
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) m_gap = draw_gap(m_quiet);
            end
        end
    end

endmodule
